@@ hdl/fltw_pkg.sv @@
// ----------------------------------------------------------------------------
// fltw_pkg: shared types and constants of the four-level page table walker
// Holds the request and response payload types, entry layout constants and
// configuration register indexes.
// ----------------------------------------------------------------------------
package fltw_pkg;

  localparam int IDX_W    = 9;
  localparam int OFS_W    = 12;
  localparam int VA_W     = 48;
  localparam int PA_W     = 52;
  localparam int ENTRY_W  = 64;
  localparam int PAGE_W   = ENTRY_W - OFS_W;
  localparam int BASE_W   = 40;
  localparam int ROOT_W   = 4;
  localparam int RSV_W    = 5;
  localparam int CFG_W    = 40;
  localparam int CFG_IDX_W = 2;

  localparam int L0_SHIFT = 39;
  localparam int L1_SHIFT = 30;
  localparam int L2_SHIFT = 21;
  localparam int L3_SHIFT = 12;

  localparam logic [OFS_W-1:0] LINK_BITS = 12'h007;

  localparam logic FUNC_TRANSLATE = 1'b0;
  localparam logic FUNC_MAP       = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROOT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = 2'd2;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef struct packed {
    logic              func;
    logic [ROOT_W-1:0] root_frame;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_target;
    logic [OFS_W-1:0]  flag_bits;
    logic              no_execute;
  } req_item_t;

  typedef struct packed {
    logic [62:0] phys_addr;
    logic        ok;
    logic        invalidate;
  } rsp_item_t;

endpackage

@@ hdl/fltw_req_if.sv @@
// ----------------------------------------------------------------------------
// fltw_req_if: request channel
// Valid/ready channel carrying one translate or map request per transaction.
// ----------------------------------------------------------------------------
interface fltw_req_if;
  logic                valid;
  logic                ready;
  fltw_pkg::req_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hdl/fltw_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fltw_rsp_if: response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface fltw_rsp_if;
  logic                valid;
  logic                ready;
  fltw_pkg::rsp_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hdl/four_level_page_table_walk_and_map.sv @@
// ----------------------------------------------------------------------------
// four_level_page_table_walk_and_map: page table walker and mapper
// Walks four-level page tables kept in an on-chip table store and maps pages,
// creating missing tables from a bump allocator.
// ----------------------------------------------------------------------------
// Requests arrive on req and results leave on rsp, one result per request.
// Configuration is written through cfg_we, cfg_index and cfg_data. The user
// must write it only while the block is idle; the block does not enforce it.
// Each table level has a state for the table store read and a state to
// check the entry, since every level depends on the entry read before it.
// A map creates each missing table by zeroing the new frame one entry a
// cycle through the single store port before it is linked.
// After reset the block zeroes the whole store and accepts no request
// until that pass is done. Configuration writes are taken during the pass.
// A result waits in an output register while the receiver stalls; the next
// request is accepted meanwhile, and its result is held until the register
// frees.
// ----------------------------------------------------------------------------
module four_level_page_table_walk_and_map #(
  parameter int TABLE_FRAMES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fltw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fltw_pkg::CFG_W-1:0]    cfg_data,
  fltw_req_if.sink                      req,
  fltw_rsp_if.source                    rsp
);

  localparam int DEPTH   = TABLE_FRAMES * 512;
  localparam int FRAME_W = $clog2(TABLE_FRAMES);
  localparam int ADDR_W  = FRAME_W + fltw_pkg::IDX_W;
  localparam int ALLOC_W = $clog2(TABLE_FRAMES + 1);
  localparam int SUM_W   = ((ALLOC_W > fltw_pkg::RSV_W) ? ALLOC_W : fltw_pkg::RSV_W) + 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_EVAL  = 8'b0000_1000,
    S_ZERO  = 8'b0001_0000,
    S_LINK  = 8'b0010_0000,
    S_LEAF  = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  state_t                        state;
  logic [ADDR_W-1:0]             sweep;
  logic [ALLOC_W-1:0]            frames_allocated;
  logic [fltw_pkg::BASE_W-1:0]   pool_base_page;
  logic [fltw_pkg::ROOT_W-1:0]   active_root_frame;
  logic [fltw_pkg::RSV_W-1:0]    reserved_frames;
  fltw_pkg::req_item_t           item;
  logic [FRAME_W-1:0]            frame;
  logic [FRAME_W-1:0]            new_frame;
  logic [1:0]                    level;
  fltw_pkg::rsp_item_t           res;
  logic                          rsp_valid;
  fltw_pkg::rsp_item_t           rsp_data;

  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_addr;
  logic [fltw_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [fltw_pkg::ENTRY_W-1:0]  ram_rdata;

  logic [fltw_pkg::IDX_W-1:0]    cur_idx;
  logic [fltw_pkg::PAGE_W-1:0]   entry_page;
  logic [fltw_pkg::PAGE_W-1:0]   page_diff;
  logic                          present;
  logic                          in_pool;
  logic [FRAME_W-1:0]            child;
  logic [SUM_W-1:0]              alloc_next;
  logic                          alloc_full;
  logic [fltw_pkg::PAGE_W-1:0]   link_page;
  logic [fltw_pkg::ENTRY_W-1:0]  leaf_entry;
  logic                          root_bad;

  fltw_ram #(
    .WIDTH(fltw_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    case (level)
      fltw_pkg::LVL_PML4: cur_idx = item.virt_addr[fltw_pkg::L0_SHIFT +: fltw_pkg::IDX_W];
      fltw_pkg::LVL_PDPT: cur_idx = item.virt_addr[fltw_pkg::L1_SHIFT +: fltw_pkg::IDX_W];
      fltw_pkg::LVL_PD:   cur_idx = item.virt_addr[fltw_pkg::L2_SHIFT +: fltw_pkg::IDX_W];
      default:            cur_idx = item.virt_addr[fltw_pkg::L3_SHIFT +: fltw_pkg::IDX_W];
    endcase
  end

  assign entry_page = ram_rdata[fltw_pkg::ENTRY_W-1:fltw_pkg::OFS_W];
  assign page_diff  = entry_page - fltw_pkg::PAGE_W'(pool_base_page);
  assign present    = ram_rdata[0];
  assign in_pool    = (entry_page >= fltw_pkg::PAGE_W'(pool_base_page)) &&
                      (page_diff < fltw_pkg::PAGE_W'(TABLE_FRAMES));
  assign child      = page_diff[FRAME_W-1:0];
  assign alloc_next = SUM_W'(reserved_frames) + SUM_W'(frames_allocated);
  assign alloc_full = alloc_next >= SUM_W'(TABLE_FRAMES);
  assign link_page  = fltw_pkg::PAGE_W'(pool_base_page) + fltw_pkg::PAGE_W'(new_frame);
  assign leaf_entry = {item.no_execute, 11'b0,
                       item.phys_target[fltw_pkg::PA_W-1:fltw_pkg::OFS_W],
                       item.flag_bits[fltw_pkg::OFS_W-1:1], 1'b1};
  assign root_bad   = 32'(req.data.root_frame) >= TABLE_FRAMES;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {frame, cur_idx};
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = sweep;
      end
      S_ZERO: begin
        ram_we   = 1'b1;
        ram_addr = {new_frame, sweep[fltw_pkg::IDX_W-1:0]};
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_wdata = {link_page, fltw_pkg::LINK_BITS};
      end
      S_LEAF: begin
        ram_we    = 1'b1;
        ram_wdata = leaf_entry;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base_page    <= '0;
      active_root_frame <= '0;
      reserved_frames   <= fltw_pkg::RSV_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        fltw_pkg::CFG_POOL_BASE:   pool_base_page    <= cfg_data;
        fltw_pkg::CFG_ACTIVE_ROOT: active_root_frame <= cfg_data[fltw_pkg::ROOT_W-1:0];
        fltw_pkg::CFG_RESERVED:    reserved_frames   <= cfg_data[fltw_pkg::RSV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_RESP && (!rsp_valid || rsp.ready)) begin
      rsp_valid <= 1'b1;
      rsp_data  <= res;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      sweep            <= '0;
      frames_allocated <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (sweep == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            item  <= req.data;
            frame <= FRAME_W'(req.data.root_frame);
            level <= fltw_pkg::LVL_PML4;
            if (root_bad) begin
              res   <= '0;
              state <= S_RESP;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (item.func == fltw_pkg::FUNC_TRANSLATE) begin
            if (!present || (level != fltw_pkg::LVL_PT && !in_pool)) begin
              res   <= '0;
              state <= S_RESP;
            end else if (level == fltw_pkg::LVL_PT) begin
              res.phys_addr  <= {ram_rdata[62:fltw_pkg::OFS_W],
                                 item.virt_addr[fltw_pkg::OFS_W-1:0]};
              res.ok         <= 1'b1;
              res.invalidate <= 1'b0;
              state          <= S_RESP;
            end else begin
              frame <= child;
              level <= level + 1'b1;
              state <= S_READ;
            end
          end else if (present) begin
            if (!in_pool) begin
              res   <= '0;
              state <= S_RESP;
            end else begin
              frame <= child;
              level <= level + 1'b1;
              state <= (level == fltw_pkg::LVL_PD) ? S_LEAF : S_READ;
            end
          end else if (alloc_full) begin
            res   <= '0;
            state <= S_RESP;
          end else begin
            new_frame        <= alloc_next[FRAME_W-1:0];
            frames_allocated <= frames_allocated + 1'b1;
            sweep            <= '0;
            state            <= S_ZERO;
          end
        end
        S_ZERO: begin
          sweep <= sweep + 1'b1;
          if (sweep[fltw_pkg::IDX_W-1:0] == {fltw_pkg::IDX_W{1'b1}}) begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          frame <= new_frame;
          level <= level + 1'b1;
          state <= (level == fltw_pkg::LVL_PD) ? S_LEAF : S_READ;
        end
        S_LEAF: begin
          res.phys_addr  <= '0;
          res.ok         <= 1'b1;
          res.invalidate <= (item.root_frame == active_root_frame);
          state          <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The bump allocator never hands out a frame beyond the pool.
  assert property (@(posedge clk) disable iff (rst)
    32'(frames_allocated) <= TABLE_FRAMES)
    else $error("frame allocator ran past the pool");

  // Every store write lands inside an existing frame.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (32'(ram_addr[ADDR_W-1:fltw_pkg::IDX_W]) < TABLE_FRAMES))
    else $error("table store write outside the pool");

  // A new result is only loaded from the response state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESP))
    else $error("result produced outside the response state");

  // Only a successful map may request an invalidate.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.invalidate) |-> (rsp_data.ok && rsp_data.phys_addr == '0))
    else $error("invalidate flagged on a failed or translate result");

endmodule

@@ hdl/fltw_ram.sv @@
// ----------------------------------------------------------------------------
// fltw_ram: generic single-port RAM
// One access per cycle, read data registered; a write returns the old word.
// ----------------------------------------------------------------------------
module fltw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
